FILE: rtl/vertex_transform_4x4_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Concurrent property checks that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_CORE_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define VT44_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VT44_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VT44_ASSERT_SAME(label, ante, cons, msg)
`define VT44_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/vt44_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt44_pkg
// Shared constants and types of the 4x4 vertex transform core.
// ----------------------------------------------------------------------------
package vt44_pkg;

    localparam int LANES     = 4;
    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int CFG_AW    = 3;
    localparam int CFG_W     = 64;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 16;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Reset matrix is the identity; register 0 is the rightmost element.
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
        64'h0001_0000_0000_0000,  // row3_cols23
        64'h0000_0000_0000_0000,  // row3_cols01
        64'h0000_0000_0001_0000,  // row2_cols23
        64'h0000_0000_0000_0000,  // row2_cols01
        64'h0000_0000_0000_0000,  // row1_cols23
        64'h0001_0000_0000_0000,  // row1_cols01
        64'h0000_0000_0000_0000,  // row0_cols23
        64'h0000_0000_0001_0000   // row0_cols01
    };

    // Load enables of the three lane pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctrl;

    // One lane's clamped component and its overflow flag.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_lane_res;

endpackage
`default_nettype wire

FILE: rtl/vt44_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt44_lane
// One output component: four products, a two-level exact sum, floor shift
// and saturation.
// ----------------------------------------------------------------------------
module vt44_lane (
    input  wire logic                                            i_clk,
    input  wire vt44_pkg::t_pipe_ctrl                            i_ctrl,
    input  wire logic [vt44_pkg::LANES-1:0][vt44_pkg::DATA_W-1:0] i_vec,
    input  wire logic [vt44_pkg::LANES-1:0][vt44_pkg::DATA_W-1:0] i_coef,
    output vt44_pkg::t_lane_res                                  o_res
);

    logic signed [vt44_pkg::PROD_W-1:0] r_prod [vt44_pkg::LANES];
    logic signed [vt44_pkg::PROD_W-1:0] n_prod [vt44_pkg::LANES];
    logic signed [vt44_pkg::PAIR_W-1:0] r_pair [2];
    logic signed [vt44_pkg::PAIR_W-1:0] n_pair [2];
    logic signed [vt44_pkg::SUM_W-1:0]  r_sum;
    logic signed [vt44_pkg::SUM_W-1:0]  n_sum;
    logic                               w_fits;

    always_comb begin
        for (int j = 0; j < vt44_pkg::LANES; j++) begin
            n_prod[j] = $signed(i_vec[j]) * $signed(i_coef[j]);
        end
        for (int k = 0; k < 2; k++) begin
            n_pair[k] = $signed({r_prod[2*k][vt44_pkg::PROD_W-1], r_prod[2*k]})
                      + $signed({r_prod[2*k+1][vt44_pkg::PROD_W-1], r_prod[2*k+1]});
        end
        n_sum = $signed({r_pair[0][vt44_pkg::PAIR_W-1], r_pair[0]})
              + $signed({r_pair[1][vt44_pkg::PAIR_W-1], r_pair[1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld1) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.ld2) begin
            r_pair <= n_pair;
        end
        if (i_ctrl.ld3) begin
            r_sum <= n_sum;
        end
    end

    // Dropping the low fraction bits is an arithmetic shift, so it rounds
    // toward minus infinity. The result fits when every bit above the new
    // sign bit copies it.
    assign w_fits = (r_sum[vt44_pkg::SUM_W-1:vt44_pkg::FRAC_BITS+vt44_pkg::DATA_W-1]
                  == {(vt44_pkg::SUM_W-vt44_pkg::FRAC_BITS-vt44_pkg::DATA_W+1)
                      {r_sum[vt44_pkg::FRAC_BITS+vt44_pkg::DATA_W-1]}});

    always_comb begin
        o_res.sat = !w_fits;
        if (w_fits) begin
            o_res.value = r_sum[vt44_pkg::FRAC_BITS +: vt44_pkg::DATA_W];
        end else if (r_sum[vt44_pkg::SUM_W-1]) begin
            o_res.value = vt44_pkg::Q_MIN;
        end else begin
            o_res.value = vt44_pkg::Q_MAX;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vt44_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vt44_merge
// Gathers the four lane results into one output transfer and holds it in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module vt44_merge (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    input  wire vt44_pkg::t_lane_res [vt44_pkg::LANES-1:0] i_res,
    input  wire logic                                     i_tready,
    output logic                                          o_ld,
    output logic                                          o_tvalid,
    output logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0]   o_tdata,
    output logic                                          o_tuser
);

    logic                                        r_valid;
    logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0] r_tdata;
    logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0] n_tdata;
    logic                                        r_tuser;
    logic                                        n_tuser;

    always_comb begin
        n_tuser = 1'b0;
        for (int i = 0; i < vt44_pkg::LANES; i++) begin
            n_tdata[i*vt44_pkg::DATA_W +: vt44_pkg::DATA_W] = i_res[i].value;
            n_tuser = n_tuser | i_res[i].sat;
        end
    end

    // The register takes a new result when it is empty or being drained.
    assign o_ld = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ld) begin
            r_valid <= i_valid;
        end
        if (o_ld && i_valid) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

endmodule
`default_nettype wire

FILE: rtl/vertex_transform_4x4_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_4x4_core
// Row-vector times 4x4 matrix in signed Q16.16, with saturation flag.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: in_x, in_y, in_z, in_w
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: out_x..out_w; tuser: saturated
// cfg       in         i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// One vertex enters per clock while s_axis_tready is high. An accepted
// vertex passes the product, pair-sum and sum registers and then the output
// register before it appears on m_axis. The rate is set by the four lanes,
// each with four 32x32 multipliers, all fully pipelined (multiply, pair add,
// final add, clamp and output register). Reset is synchronous and active
// low; it empties the pipeline and loads the identity matrix. A stalled
// output only stops the stages behind it that are full: bubbles still fill,
// so the input keeps taking transfers until every stage holds a vertex.
//
// The matrix is written through the cfg port; register i holds two entries
// of row i/2, the lower column in bits 31..0. Write it only while idle.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_core_assert.svh"

module vertex_transform_4x4_core (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    // in_x [31:0], in_y [63:32], in_z [95:64], in_w [127:96]
    input  wire logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0]    s_axis_tdata,
    input  wire logic                                           s_axis_tvalid,
    output logic                                                s_axis_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0]         m_axis_tdata,
    // saturated [0]
    output logic                                                m_axis_tuser,
    output logic                                                m_axis_tvalid,
    input  wire logic                                           m_axis_tready,
    input  wire logic                                           i_cfg_we,
    input  wire logic [vt44_pkg::CFG_AW-1:0]                    i_cfg_addr,
    input  wire logic [vt44_pkg::CFG_W-1:0]                     i_cfg_wdata
);

    // Matrix registers, written directly from the configuration port.
    logic [vt44_pkg::CFG_W-1:0] r_cfg [vt44_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < vt44_pkg::NUM_REGS; r++) begin
                r_cfg[r] <= vt44_pkg::CFG_RESET[r];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Stage valid flags and the load chain. A stage loads when it is empty
    // or when the stage after it loads in the same cycle.
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 w_ld_out;
    vt44_pkg::t_pipe_ctrl w_ctrl;

    always_comb begin
        w_ctrl.ld3 = !r_v3 || w_ld_out;
        w_ctrl.ld2 = !r_v2 || w_ctrl.ld3;
        w_ctrl.ld1 = !r_v1 || w_ctrl.ld2;
    end

    assign s_axis_tready = w_ctrl.ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctrl.ld1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_ctrl.ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ctrl.ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Lane i computes out[i] from column i of the matrix. Entry M[j][i] sits
    // in register 2*j + i/2, in the upper half when i is odd.
    logic [vt44_pkg::LANES-1:0][vt44_pkg::DATA_W-1:0] w_vec;
    vt44_pkg::t_lane_res [vt44_pkg::LANES-1:0]        w_res;

    assign w_vec = s_axis_tdata;

    for (genvar gi = 0; gi < vt44_pkg::LANES; gi++) begin : g_lane
        logic [vt44_pkg::LANES-1:0][vt44_pkg::DATA_W-1:0] w_coef;

        for (genvar gj = 0; gj < vt44_pkg::LANES; gj++) begin : g_coef
            assign w_coef[gj] =
                r_cfg[2*gj + gi/2][(gi%2)*vt44_pkg::DATA_W +: vt44_pkg::DATA_W];
        end

        vt44_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_vec  (w_vec),
            .i_coef (w_coef),
            .o_res  (w_res[gi])
        );
    end

    vt44_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v3),
        .i_res    (w_res),
        .i_tready (m_axis_tready),
        .o_ld     (w_ld_out),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    // True when any component of a result sits at one of the clamp limits.
    function automatic logic clamped(
        input logic [vt44_pkg::LANES*vt44_pkg::DATA_W-1:0] data
    );
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < vt44_pkg::LANES; i++) begin
            if ((data[i*vt44_pkg::DATA_W +: vt44_pkg::DATA_W] == vt44_pkg::Q_MAX)
                    || (data[i*vt44_pkg::DATA_W +: vt44_pkg::DATA_W] == vt44_pkg::Q_MIN)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // A flagged result must carry at least one clamped component.
    `VT44_ASSERT_SAME(a_sat_clamp, m_axis_tvalid && m_axis_tuser, clamped(m_axis_tdata), "no clamp")
    // An accepted vertex occupies the first stage on the next cycle.
    `VT44_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, r_v1, "vertex lost")
    // A full last stage that cannot drain keeps its vertex.
    `VT44_ASSERT_NEXT(a_s3_holds, r_v3 && !w_ld_out, r_v3, "stage three dropped a stalled vertex")

endmodule
`default_nettype wire
